[rtl/lcvs_pkg.sv]
// ----------------------------------------------------------------------------
// lcvs_pkg
// Shared types, codes and the factory image of the configuration variable
// store.
// ----------------------------------------------------------------------------
package lcvs_pkg;

    localparam int unsigned HIGHEST_NUMBER = 255;
    localparam int unsigned STORE_DEPTH    = 256;
    localparam int unsigned ADDR_W         = 8;
    localparam int unsigned CV_W           = 10;
    localparam int unsigned DATA_W         = 8;
    localparam int unsigned KIND_W         = 2;
    localparam int unsigned STATUS_W       = 2;

    localparam logic [KIND_W-1:0] KIND_READ      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WRITE_BIT = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_LOCKED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FACTORY = 2'd3;

    localparam logic [ADDR_W-1:0] LOCK_A      = 8'd15;
    localparam logic [ADDR_W-1:0] LOCK_B      = 8'd16;
    localparam logic [ADDR_W-1:0] RO_ENTRY    = 8'd7;
    localparam logic [ADDR_W-1:0] RESET_ENTRY = 8'd8;
    localparam logic [ADDR_W-1:0] LAST_ENTRY  = 8'd255;

    localparam logic [DATA_W-1:0] MAKER_CODE     = 8'h0D;
    localparam logic [DATA_W-1:0] ALT_RESET_CODE = 8'h08;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CV_W-1:0]   cv_number;
        logic [DATA_W-1:0] data;
    } req_t;

    typedef struct packed {
        logic                wr_en;
        logic                factory;
        logic [ADDR_W-1:0]   addr;
        logic [DATA_W-1:0]   value;
        logic [DATA_W-1:0]   read_data;
        logic [STATUS_W-1:0] status;
    } rmw_t;

    function automatic logic [DATA_W-1:0] factory_default(input logic [ADDR_W-1:0] idx);
        logic [DATA_W-1:0] val;
        unique case (idx)
            8'd1:    val = 8'd3;
            8'd5:    val = 8'hFF;
            8'd6:    val = 8'd127;
            8'd7:    val = 8'h03;
            8'd8:    val = MAKER_CODE;
            8'd17:   val = 8'd192;
            8'd29:   val = 8'h06;
            8'd34:   val = 8'h06;
            8'd36:   val = 8'h01;
            8'd37:   val = 8'hFF;
            8'd47:   val = 8'hCA;
            8'd56:   val = 8'h04;
            8'd58:   val = 8'h7F;
            8'd59:   val = 8'h03;
            8'd67:   val = 8'd9;
            8'd68:   val = 8'd18;
            8'd69:   val = 8'd27;
            8'd70:   val = 8'd36;
            8'd71:   val = 8'd46;
            8'd72:   val = 8'd55;
            8'd73:   val = 8'd64;
            8'd74:   val = 8'd73;
            8'd75:   val = 8'd82;
            8'd76:   val = 8'd91;
            8'd77:   val = 8'd100;
            8'd78:   val = 8'd109;
            8'd79:   val = 8'd118;
            8'd80:   val = 8'd128;
            8'd81:   val = 8'd137;
            8'd82:   val = 8'd146;
            8'd83:   val = 8'd155;
            8'd84:   val = 8'd164;
            8'd85:   val = 8'd173;
            8'd86:   val = 8'd182;
            8'd87:   val = 8'd191;
            8'd88:   val = 8'd200;
            8'd89:   val = 8'd209;
            8'd90:   val = 8'd219;
            8'd91:   val = 8'd228;
            8'd92:   val = 8'd237;
            8'd93:   val = 8'd246;
            8'd94:   val = 8'd255;
            default: val = 8'd0;
        endcase
        return val;
    endfunction

    // Entries that a factory restore returns to their defaults.
    function automatic logic [STORE_DEPTH-1:0] restore_mask();
        logic [STORE_DEPTH-1:0] m;
        m = '0;
        for (int unsigned i = 0; i < STORE_DEPTH; i++) begin
            m[i] = (i == 0) || ((i < STORE_DEPTH - 1) && (i < HIGHEST_NUMBER));
        end
        return m;
    endfunction

endpackage

[rtl/lcvs_if.sv]
// ----------------------------------------------------------------------------
// lcvs_req_if / lcvs_rsp_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface lcvs_req_if;
    import lcvs_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [CV_W-1:0]   cv_number;
    logic [DATA_W-1:0] data;

    modport source (output valid, output kind, output cv_number, output data, input ready);
    modport sink (input valid, input kind, input cv_number, input data, output ready);
endinterface

interface lcvs_rsp_if;
    import lcvs_pkg::*;

    logic                valid;
    logic                ready;
    logic [DATA_W-1:0]   read_data;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output read_data, output status, input ready);
    modport sink (input valid, input read_data, input status, output ready);
endinterface

[rtl/lcvs_ram.sv]
// ----------------------------------------------------------------------------
// lcvs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lcvs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/lcvs_rmw_unit.sv]
// ----------------------------------------------------------------------------
// lcvs_rmw_unit
// Read-modify-write unit: merges a bit or byte into the fetched entry and
// applies the range, lock, read-only and factory-reset rules.
// ----------------------------------------------------------------------------
module lcvs_rmw_unit (
    input  lcvs_pkg::req_t                  req,
    input  logic [lcvs_pkg::DATA_W-1:0]     ram_rdata,
    input  logic                            entry_valid,
    input  logic [lcvs_pkg::DATA_W-1:0]     lock_a,
    input  logic [lcvs_pkg::DATA_W-1:0]     lock_b,
    output lcvs_pkg::rmw_t                  res
);
    import lcvs_pkg::*;

    logic              in_range;
    logic [ADDR_W-1:0] idx;
    logic [DATA_W-1:0] stored;
    logic [DATA_W-1:0] cur;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] merged;
    logic [DATA_W-1:0] value;
    logic              is_write;
    logic              locked;

    always_comb
    begin
        in_range = req.cv_number <= CV_W'(HIGHEST_NUMBER);
        idx      = req.cv_number[ADDR_W-1:0];
        stored   = entry_valid ? ram_rdata : factory_default(idx);
        cur      = in_range ? stored : '0;
        mask     = 8'b1 << req.data[2:0];
        merged   = req.data[3] ? (cur | mask) : (cur & ~mask);
        value    = (req.kind == KIND_WRITE) ? req.data : merged;
        is_write = (req.kind == KIND_WRITE) || (req.kind == KIND_WRITE_BIT);
        locked   = (idx != LOCK_A) && (idx != LOCK_B) && (lock_a != lock_b);

        res.wr_en     = 1'b0;
        res.factory   = 1'b0;
        res.addr      = idx;
        res.value     = value;
        res.read_data = cur;
        res.status    = in_range ? ST_DONE : ST_REFUSED;

        if (is_write && in_range)
        begin
            priority if (locked)
            begin
                res.status = ST_LOCKED;
            end
            else if (idx == RO_ENTRY)
            begin
                res.status = ST_REFUSED;
            end
            else if (idx == RESET_ENTRY)
            begin
                if ((value == MAKER_CODE) || (value == ALT_RESET_CODE))
                begin
                    res.factory   = 1'b1;
                    res.status    = ST_FACTORY;
                    res.read_data = factory_default(RESET_ENTRY);
                end
                else
                begin
                    res.status = ST_REFUSED;
                end
            end
            else
            begin
                res.wr_en     = 1'b1;
                res.read_data = value;
            end
        end
    end

endmodule

[rtl/locked_config_variable_store_core.sv]
// ----------------------------------------------------------------------------
// locked_config_variable_store_core
// Locked 256-entry configuration variable store with read, byte-write and
// bit-write requests.
// ----------------------------------------------------------------------------
// The req channel carries one request word (kind, cv_number, data); the rsp
// channel returns one result word (read_data, status) for each request.
// A request is taken in the idle state, the entry is fetched from the RAM
// in the next cycle, and in the lookup cycle the read-modify-write unit
// decides the outcome, writes the RAM and loads the result register.
// A request moves from the idle state to the lookup state, and the result
// is registered when the lookup finishes; no request is taken meanwhile.
// A new request can be accepted while a result still waits in the output
// register. If the receiver stalls, the block holds in its lookup cycle
// until the result register is free, with the RAM address kept steady.
// Reset clears the per-entry valid bits so that every entry reads its
// factory default, with entry zero cleared; a factory restore clears those
// of entries 0 to 254 together and keeps entry 255. No clearing pass runs.
// ----------------------------------------------------------------------------
module locked_config_variable_store_core (
    input  logic             clk,
    input  logic             rst_n,
    lcvs_req_if.sink         req,
    lcvs_rsp_if.source       rsp
);
    import lcvs_pkg::*;

    typedef enum logic {S_IDLE, S_LOOKUP} state_t;

    localparam logic [STORE_DEPTH-1:0] RESTORE_MASK = restore_mask();

    state_t                 state_reg, state_next;
    req_t                   item_reg, item_next;
    logic [STORE_DEPTH-1:0] valid_reg, valid_next;
    logic [DATA_W-1:0]      lock_a_reg, lock_a_next;
    logic [DATA_W-1:0]      lock_b_reg, lock_b_next;
    logic                   out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]      out_data_reg, out_data_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;

    logic                   accept;
    logic                   finish;
    logic [ADDR_W-1:0]      raddr;
    logic [DATA_W-1:0]      ram_rdata;
    logic                   ram_we;
    rmw_t                   rmw;

    assign req.ready     = (state_reg == S_IDLE);
    assign accept        = req.valid && req.ready;
    assign finish        = (state_reg == S_LOOKUP) && (!out_valid_reg || rsp.ready);
    assign raddr         = accept ? req.cv_number[ADDR_W-1:0] : item_reg.cv_number[ADDR_W-1:0];
    assign ram_we        = finish && rmw.wr_en;
    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_data_reg;
    assign rsp.status    = out_status_reg;

    lcvs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (rmw.addr),
        .wdata (rmw.value),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    lcvs_rmw_unit u_rmw (
        .req         (item_reg),
        .ram_rdata   (ram_rdata),
        .entry_valid (valid_reg[item_reg.cv_number[ADDR_W-1:0]]),
        .lock_a      (lock_a_reg),
        .lock_b      (lock_b_reg),
        .res         (rmw)
    );

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        valid_next      = valid_reg;
        lock_a_next     = lock_a_reg;
        lock_b_next     = lock_b_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    item_next.kind      = req.kind;
                    item_next.cv_number = req.cv_number;
                    item_next.data      = req.data;
                    state_next          = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (finish)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = rmw.read_data;
                    out_status_next = rmw.status;
                    state_next      = S_IDLE;
                    if (rmw.factory)
                    begin
                        valid_next  = valid_reg & ~RESTORE_MASK;
                        lock_a_next = factory_default(LOCK_A);
                        lock_b_next = factory_default(LOCK_B);
                    end
                    if (rmw.wr_en)
                    begin
                        valid_next[rmw.addr] = 1'b1;
                        if (rmw.addr == LOCK_A)
                        begin
                            lock_a_next = rmw.value;
                        end
                        if (rmw.addr == LOCK_B)
                        begin
                            lock_b_next = rmw.value;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            item_reg       <= '0;
            valid_reg      <= '0;
            lock_a_reg     <= factory_default(LOCK_A);
            lock_b_reg     <= factory_default(LOCK_B);
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            out_status_reg <= ST_DONE;
        end
        else
        begin
            state_reg      <= state_next;
            item_reg       <= item_next;
            valid_reg      <= valid_next;
            lock_a_reg     <= lock_a_next;
            lock_b_reg     <= lock_b_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
            out_status_reg <= out_status_next;
        end
    end

    a_write_only_in_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_LOOKUP))
        else $error("RAM written outside the lookup cycle");

    a_finish_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> out_valid_reg && (state_reg == S_IDLE))
        else $error("finished request did not load the result register");

    a_write_respects_lock: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((lock_a_reg == lock_b_reg) || (rmw.addr == LOCK_A)
                    || (rmw.addr == LOCK_B)))
        else $error("entry written while the store is locked");

    a_factory_clears_entry8: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && rmw.factory) |=> !valid_reg[RESET_ENTRY])
        else $error("factory restore left entry 8 modified");

    a_lock_regs_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && rmw.factory) |=> (lock_a_reg == lock_b_reg))
        else $error("factory restore left the store locked");

endmodule

[dv/locked_config_variable_store_core_test.sv]
// ----------------------------------------------------------------------------
// locked_config_variable_store_core_test
// Self-checking bench for the locked configuration variable store. A table
// of directed requests covers reset contents, range limits, the decoder lock,
// the read-only entry and factory restore. Random traffic follows, mostly
// with the lock open. Each result word is compared with its table entry or
// with a behavioral shadow of the store; both channels stall at random.
// ----------------------------------------------------------------------------
module locked_config_variable_store_core_test;
    import lcvs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam int N_DIRECTED   = 25;
    localparam int RANDOM_ITEMS = 1725;
    localparam int TOTAL_ITEMS  = N_DIRECTED + RANDOM_ITEMS;
    localparam int STEADY_TAIL  = 200;
    localparam int HOLD_AT      = 600;
    localparam int HOLD_CYCLES  = 120;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;

    localparam logic [DATA_W-1:0] RAMP [28] = '{
        8'd9, 8'd18, 8'd27, 8'd36, 8'd46, 8'd55, 8'd64, 8'd73, 8'd82, 8'd91,
        8'd100, 8'd109, 8'd118, 8'd128, 8'd137, 8'd146, 8'd155, 8'd164, 8'd173,
        8'd182, 8'd191, 8'd200, 8'd209, 8'd219, 8'd228, 8'd237, 8'd246, 8'd255
    };

    typedef struct packed {
        logic [DATA_W-1:0]   read_data;
        logic [STATUS_W-1:0] status;
    } cv_reply_t;

    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic [CV_W-1:0]     cv;
        logic [DATA_W-1:0]   data;
        bit                  known;
        logic [DATA_W-1:0]   read_data;
        logic [STATUS_W-1:0] status;
    } cv_request_row_t;

    logic clk;
    logic rst_n;

    lcvs_req_if req_ch ();
    lcvs_rsp_if rsp_ch ();

    locked_config_variable_store_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic [DATA_W-1:0] shadow_cv [STORE_DEPTH];
    cv_reply_t         pending_replies [$];
    cv_request_row_t   directed_rows [N_DIRECTED];
    cv_reply_t         got_reply;
    cv_reply_t         want_reply;

    int  sent;
    int  errors;
    int  idle_cycles;
    int  n_read;
    int  n_write;
    int  n_bit;
    int  n_locked;
    int  n_refused;
    int  n_factory;
    bit  steady;
    bit  calm;
    bit  hold_done;

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [DATA_W-1:0] default_value(input int unsigned idx);
        logic [DATA_W-1:0] v;
        v = '0;
        if (idx >= 67 && idx <= 94)
        begin
            v = RAMP[idx - 67];
        end
        else
        begin
            case (idx)
                1:           v = 8'd3;
                5:           v = 8'hFF;
                6:           v = 8'd127;
                RO_ENTRY:    v = 8'h03;
                RESET_ENTRY: v = MAKER_CODE;
                17:          v = 8'd192;
                29:          v = 8'h06;
                34:          v = 8'h06;
                36:          v = 8'h01;
                37:          v = 8'hFF;
                47:          v = 8'hCA;
                56:          v = 8'h04;
                58:          v = 8'h7F;
                59:          v = 8'h03;
                default:     v = '0;
            endcase
        end
        return v;
    endfunction

    function automatic void restore_defaults();
        for (int unsigned i = 1; i < STORE_DEPTH - 1; i++)
        begin
            if (i < HIGHEST_NUMBER)
            begin
                shadow_cv[i] = default_value(i);
            end
        end
        shadow_cv[0] = '0;
    endfunction

    function automatic logic [STATUS_W-1:0] commit_byte(input logic [CV_W-1:0] cv,
                                                        input logic [DATA_W-1:0] value);
        logic [ADDR_W-1:0] idx;
        idx = cv[ADDR_W-1:0];
        if (cv > HIGHEST_NUMBER)
        begin
            return ST_REFUSED;
        end
        if (idx != LOCK_A && idx != LOCK_B && shadow_cv[LOCK_A] != shadow_cv[LOCK_B])
        begin
            return ST_LOCKED;
        end
        if (idx == RO_ENTRY)
        begin
            return ST_REFUSED;
        end
        if (idx == RESET_ENTRY)
        begin
            if (value == MAKER_CODE || value == ALT_RESET_CODE)
            begin
                restore_defaults();
                return ST_FACTORY;
            end
            return ST_REFUSED;
        end
        shadow_cv[idx] = value;
        return ST_DONE;
    endfunction

    function automatic cv_reply_t predict_reply(input logic [KIND_W-1:0] kind,
                                                input logic [CV_W-1:0]   cv,
                                                input logic [DATA_W-1:0] data);
        cv_reply_t         r;
        logic              in_range;
        logic [ADDR_W-1:0] idx;
        logic [DATA_W-1:0] cur;
        in_range = (cv <= HIGHEST_NUMBER);
        idx      = cv[ADDR_W-1:0];
        case (kind)
            KIND_WRITE:
            begin
                r.status = commit_byte(cv, data);
            end
            KIND_WRITE_BIT:
            begin
                cur = in_range ? shadow_cv[idx] : '0;
                cur[data[2:0]] = data[3];
                r.status = commit_byte(cv, cur);
            end
            default:
            begin
                r.status = in_range ? ST_DONE : ST_REFUSED;
            end
        endcase
        r.read_data = in_range ? shadow_cv[idx] : '0;
        return r;
    endfunction

    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [CV_W-1:0] cv,
                                input logic [DATA_W-1:0] data, input bit known,
                                input cv_reply_t typed);
        cv_reply_t r;
        if (!steady && !calm && $urandom_range(3) == 0)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(8, 1) - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid     <= 1'b1;
        req_ch.kind      <= kind;
        req_ch.cv_number <= cv;
        req_ch.data      <= data;
        do @(posedge clk); while (!req_ch.ready);
        r = predict_reply(kind, cv, data);
        pending_replies.push_back(known ? typed : r);
        case (kind)
            KIND_WRITE:     n_write++;
            KIND_WRITE_BIT: n_bit++;
            default:        n_read++;
        endcase
        case (r.status)
            ST_LOCKED:  n_locked++;
            ST_REFUSED: n_refused++;
            ST_FACTORY: n_factory++;
            default:    ;
        endcase
        sent++;
        steady = (sent >= TOTAL_ITEMS - STEADY_TAIL);
        calm   = ((sent / 150) % 4 == 3);
    endtask

    task automatic pick_request(output logic [KIND_W-1:0] kind, output logic [CV_W-1:0] cv,
                                output logic [DATA_W-1:0] data);
        int k;
        int s;
        k    = $urandom_range(99);
        s    = $urandom_range(99);
        data = DATA_W'($urandom_range(255));
        if (k < 30)
            kind = KIND_READ;
        else if (k < 65)
            kind = KIND_WRITE;
        else if (k < 95)
            kind = KIND_WRITE_BIT;
        else
            kind = KIND_SPARE;
        if (s < 15)
        begin
            cv = CV_W'($urandom_range(1023, 256));
        end
        else if (s < 35)
        begin
            case ($urandom_range(7))
                0:       cv = 10'd0;
                1:       cv = CV_W'(RO_ENTRY);
                2:       cv = CV_W'(RESET_ENTRY);
                3:       cv = CV_W'(LOCK_A);
                4:       cv = CV_W'(LOCK_B);
                5:       cv = CV_W'(LAST_ENTRY);
                6:       cv = 10'd1;
                default: cv = 10'd94;
            endcase
        end
        else
        begin
            cv = CV_W'($urandom_range(255));
        end
        if (kind == KIND_WRITE && cv == LOCK_A && $urandom_range(3) != 0)
            data = shadow_cv[LOCK_B];
        if (kind == KIND_WRITE && cv == LOCK_B && $urandom_range(3) != 0)
            data = shadow_cv[LOCK_A];
        if (kind == KIND_WRITE && cv == RESET_ENTRY && $urandom_range(1) == 0)
            data = $urandom_range(1) ? MAKER_CODE : ALT_RESET_CODE;
        if (shadow_cv[LOCK_A] != shadow_cv[LOCK_B] && $urandom_range(7) == 0)
        begin
            kind = KIND_WRITE;
            cv   = CV_W'(LOCK_A);
            data = shadow_cv[LOCK_B];
        end
    endtask

    initial
    begin
        logic [KIND_W-1:0] kind;
        logic [CV_W-1:0]   cv;
        logic [DATA_W-1:0] data;
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.kind      = KIND_READ;
        req_ch.cv_number = '0;
        req_ch.data      = '0;
        sent             = 0;
        errors           = 0;
        steady           = 1'b0;
        calm             = 1'b0;
        shadow_cv[LAST_ENTRY] = default_value(int'(LAST_ENTRY));
        restore_defaults();
        directed_rows = '{
            '{KIND_READ,      10'd0,    8'h00, 1'b1, 8'h00, ST_DONE},
            '{KIND_READ,      10'd1,    8'h00, 1'b1, 8'h03, ST_DONE},
            '{KIND_READ,      10'd255,  8'hFF, 1'b1, 8'h00, ST_DONE},
            '{KIND_READ,      10'd256,  8'h00, 1'b1, 8'h00, ST_REFUSED},
            '{KIND_READ,      10'd1023, 8'hFF, 1'b1, 8'h00, ST_REFUSED},
            '{KIND_SPARE,     10'd94,   8'h00, 1'b1, 8'hFF, ST_DONE},
            '{KIND_WRITE,     10'd7,    8'h55, 1'b1, 8'h03, ST_REFUSED},
            '{KIND_WRITE,     10'd1023, 8'hFF, 1'b1, 8'h00, ST_REFUSED},
            '{KIND_WRITE,     10'd255,  8'hFF, 1'b1, 8'hFF, ST_DONE},
            '{KIND_WRITE,     10'd0,    8'hA5, 1'b1, 8'hA5, ST_DONE},
            '{KIND_WRITE,     10'd8,    8'h42, 1'b1, 8'h0D, ST_REFUSED},
            '{KIND_WRITE,     10'd15,   8'h5A, 1'b1, 8'h5A, ST_DONE},
            '{KIND_WRITE,     10'd1,    8'h77, 1'b1, 8'h03, ST_LOCKED},
            '{KIND_WRITE_BIT, 10'd1,    8'h0F, 1'b1, 8'h03, ST_LOCKED},
            '{KIND_WRITE,     10'd8,    8'h0D, 1'b1, 8'h0D, ST_LOCKED},
            '{KIND_WRITE,     10'd7,    8'h00, 1'b1, 8'h03, ST_LOCKED},
            '{KIND_WRITE,     10'd16,   8'h5A, 1'b1, 8'h5A, ST_DONE},
            '{KIND_WRITE_BIT, 10'd1,    8'h0F, 1'b0, 8'h00, ST_DONE},
            '{KIND_WRITE_BIT, 10'd5,    8'h00, 1'b0, 8'h00, ST_DONE},
            '{KIND_WRITE_BIT, 10'd300,  8'hF8, 1'b1, 8'h00, ST_REFUSED},
            '{KIND_WRITE_BIT, 10'd7,    8'h0F, 1'b1, 8'h03, ST_REFUSED},
            '{KIND_WRITE_BIT, 10'd8,    8'h00, 1'b1, 8'h0D, ST_REFUSED},
            '{KIND_WRITE,     10'd8,    8'h08, 1'b1, 8'h0D, ST_FACTORY},
            '{KIND_READ,      10'd255,  8'h00, 1'b1, 8'hFF, ST_DONE},
            '{KIND_READ,      10'd0,    8'h00, 1'b1, 8'h00, ST_DONE}
        };
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].kind, directed_rows[i].cv, directed_rows[i].data,
                         directed_rows[i].known,
                         '{directed_rows[i].read_data, directed_rows[i].status});
        end
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick_request(kind, cv, data);
            send_request(kind, cv, data, 1'b0, '0);
        end
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d requests: %0d reads, %0d byte writes, %0d bit writes.",
                 sent, n_read, n_write, n_bit);
        $display("Outcomes: %0d locked out, %0d refused, %0d factory restores; %s %0d cycles.",
                 n_locked, n_refused, n_factory, "longest result stall", HOLD_CYCLES);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        rsp_ch.ready = 1'b0;
        hold_done    = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && sent >= HOLD_AT)
            begin
                hold_done = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                rsp_ch.ready <= 1'b1;
            end
            else if (!steady && !calm && $urandom_range(4) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(8, 1)) @(negedge clk);
                rsp_ch.ready <= 1'b1;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got_reply = '{rsp_ch.read_data, rsp_ch.status};
            if (pending_replies.size() == 0)
            begin
                $error("result word with no request waiting: read_data=0x%02h status=%0d",
                       got_reply.read_data, got_reply.status);
                errors++;
            end
            else
            begin
                want_reply = pending_replies.pop_front();
                if (got_reply.read_data !== want_reply.read_data)
                begin
                    $error("read_data mismatch: expected 0x%02h, actual 0x%02h",
                           want_reply.read_data, got_reply.read_data);
                    errors++;
                end
                if (got_reply.status !== want_reply.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want_reply.status, got_reply.status);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial idle_cycles = 0;

endmodule
